/* sv/asdh_pkg.sv */
`timescale 1ns / 1ps
// Shared types and sizing constants for the sharpness histogram block.
// No dependencies; every other file imports this package.
package asdh_pkg;

    // Frame and store sizing
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAX_STEP   = 4;
    localparam int BIN_COUNT  = 256;

    // Register field widths
    localparam int FW_W       = 12;
    localparam int FH_W       = 12;
    localparam int STEP_W     = 3;
    localparam int INDENT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Payload widths
    localparam int REQ_W   = 2;
    localparam int PIX_W   = 8;
    localparam int BIN_W   = $clog2(BIN_COUNT);
    localparam int COUNT_W = 32;

    // Position and line store addressing
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int SPAN_MAX  = 2 * MAX_STEP;
    localparam int SLOT_W    = $clog2(SPAN_MAX);
    localparam int LS_DEPTH  = SPAN_MAX * MAX_WIDTH;
    localparam int LS_ADDR_W = $clog2(LS_DEPTH);
    localparam int SH_IDX_W  = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int CALC_W    = 16;

    // Result queue; depth is a power of two so the pointers wrap freely
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    // Request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_DERIV_STEP    = 2'd2,
        REG_BORDER_INDENT = 2'd3
    } cfg_reg_t;

    // Histogram operations
    typedef enum logic [1:0] {
        HOP_INC   = 2'd0,
        HOP_READ  = 2'd1,
        HOP_CLEAR = 2'd2
    } hop_t;

    // Word entering the line store stage
    typedef struct packed {
        logic                 valid;
        logic                 is_pixel;
        logic                 count_en;
        hop_t                 op;
        logic [PIX_W-1:0]     pix;
        logic [BIN_W-1:0]     bin;
        logic [LS_ADDR_W-1:0] addr_now;
        logic [LS_ADDR_W-1:0] addr_mid;
    } ls_req_t;

    // Operation handed to the histogram stage
    typedef struct packed {
        logic             valid;
        hop_t             op;
        logic [BIN_W-1:0] bin;
    } hist_op_t;

    // Read result leaving the histogram stage
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
        logic [BIN_W-1:0]   bin;
    } hist_res_t;

endpackage

/* sv/asdh_req_if.sv */
`timescale 1ns / 1ps
// Input channel: pixels and bin read requests with valid/ready.
// Depends on asdh_pkg.
interface asdh_req_if import asdh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [PIX_W-1:0] pixel_value;
    logic [BIN_W-1:0] bin_select;

    modport source (output valid, output req_type, output pixel_value, output bin_select,
                    input ready);
    modport sink   (input valid, input req_type, input pixel_value, input bin_select,
                    output ready);
endinterface

/* sv/asdh_res_if.sv */
`timescale 1ns / 1ps
// Output channel: bin count results with valid/ready.
// Depends on asdh_pkg.
interface asdh_res_if import asdh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] bin_count;
    logic [BIN_W-1:0]   bin_echo;

    modport source (output valid, output bin_count, output bin_echo, input ready);
    modport sink   (input valid, input bin_count, input bin_echo, output ready);
endinterface

/* sv/asdh_deriv.sv */
`timescale 1ns / 1ps
// Line store and second derivative stage: turns pixel words into bin increments.
// Depends on asdh_pkg.
module asdh_deriv import asdh_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] step,
    input  ls_req_t           req,
    output hist_op_t          op
);

    logic [PIX_W-1:0] line_mem [LS_DEPTH];
    logic [PIX_W-1:0] old_rd;
    logic [PIX_W-1:0] mid_rd;

    ls_req_t  s1_reg;
    hist_op_t op_reg;
    hist_op_t op_next;

    logic [PIX_W-1:0] below_sh_reg [MAX_STEP];
    logic [PIX_W-1:0] above_sh_reg [MAX_STEP];
    logic [PIX_W-1:0] mid_sh_reg   [SPAN_MAX];

    logic [STEP_W-1:0] step_m1;
    logic [STEP_W:0]   span_m1;
    logic [SH_IDX_W-1:0] near_idx;
    logic [SLOT_W-1:0]   far_idx;

    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] left_pix;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] below;
    logic [PIX_W-1:0] h_term;
    logic [PIX_W-1:0] v_term;
    logic [PIX_W-1:0] value;

    function automatic logic [PIX_W-1:0] second_deriv(
        input logic [PIX_W-1:0] lo,
        input logic [PIX_W-1:0] mid,
        input logic [PIX_W-1:0] hi
    );
        logic [PIX_W:0]   sum;
        logic [PIX_W-1:0] avg;
        sum = {1'b0, lo} + {1'b0, hi} + {{PIX_W{1'b0}}, 1'b1};
        avg = sum[PIX_W:1];
        return (avg > mid) ? avg - mid : mid - avg;
    endfunction

    // Read the old entry of this row's slot and the centre row, write the new pixel
    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            old_rd <= line_mem[req.addr_now];
            mid_rd <= line_mem[req.addr_mid];
        end
        if (req.valid && req.is_pixel)
        begin
            line_mem[req.addr_now] <= req.pix;
        end
    end

    // Hold the word alongside its line store reads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= req;
        end
    end

    // Advance the column delay lines on every pixel
    always_ff @(posedge clk)
    begin
        if (s1_reg.valid && s1_reg.is_pixel)
        begin
            below_sh_reg[0] <= s1_reg.pix;
            above_sh_reg[0] <= old_rd;
            mid_sh_reg[0]   <= mid_rd;
            for (int k = 1; k < MAX_STEP; k++)
            begin
                below_sh_reg[k] <= below_sh_reg[k-1];
                above_sh_reg[k] <= above_sh_reg[k-1];
            end
            for (int k = 1; k < SPAN_MAX; k++)
            begin
                mid_sh_reg[k] <= mid_sh_reg[k-1];
            end
        end
    end

    // Pick the neighbours step and 2*step pixels back
    assign step_m1  = step - {{(STEP_W-1){1'b0}}, 1'b1};
    assign span_m1  = {step, 1'b0} - {{STEP_W{1'b0}}, 1'b1};
    assign near_idx = step_m1[SH_IDX_W-1:0];
    assign far_idx  = span_m1[SLOT_W-1:0];

    assign centre   = mid_sh_reg[near_idx];
    assign left_pix = mid_sh_reg[far_idx];
    assign above    = above_sh_reg[near_idx];
    assign below    = below_sh_reg[near_idx];

    assign h_term = second_deriv(left_pix, centre, mid_rd);
    assign v_term = second_deriv(above, centre, below);
    assign value  = (h_term > v_term) ? h_term : v_term;

    // Build the histogram operation
    always_comb
    begin
        op_next.valid = s1_reg.valid && (!s1_reg.is_pixel || s1_reg.count_en);
        op_next.op    = s1_reg.is_pixel ? HOP_INC : s1_reg.op;
        op_next.bin   = s1_reg.is_pixel ? BIN_W'(value) : s1_reg.bin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else
        begin
            op_reg <= op_next;
        end
    end

    assign op = op_reg;

endmodule

/* sv/asdh_hist.sv */
`timescale 1ns / 1ps
// Histogram of 32-bit bin counters: increment, read and read-then-clear.
// Depends on asdh_pkg.
module asdh_hist import asdh_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  hist_op_t  op,
    output hist_res_t res
);

    logic [COUNT_W-1:0]   bin_mem [BIN_COUNT];
    logic [COUNT_W-1:0]   rd_data;
    logic [BIN_COUNT-1:0] filled_reg;

    hist_op_t s3_reg;

    logic               fwd_valid_reg;
    logic [BIN_W-1:0]   fwd_bin_reg;
    logic [COUNT_W-1:0] fwd_data_reg;

    logic               wr_en;
    logic [COUNT_W-1:0] wr_data;
    logic [COUNT_W-1:0] base;

    // Read the bin as the operation enters, write it back in the next cycle
    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            rd_data <= bin_mem[op.bin];
        end
        if (wr_en)
        begin
            bin_mem[s3_reg.bin] <= wr_data;
        end
    end

    // Hold the operation while its read completes; track written bins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg        <= '0;
            filled_reg    <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s3_reg <= op;
            if (wr_en)
            begin
                filled_reg[s3_reg.bin] <= 1'b1;
                fwd_valid_reg          <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_bin_reg  <= s3_reg.bin;
            fwd_data_reg <= wr_data;
        end
    end

    // Take the latest write over a read that raced it; unwritten bins are zero
    always_comb
    begin
        priority if (fwd_valid_reg && fwd_bin_reg == s3_reg.bin)
        begin
            base = fwd_data_reg;
        end
        else if (filled_reg[s3_reg.bin])
        begin
            base = rd_data;
        end
        else
        begin
            base = '0;
        end
    end

    // Modify the count
    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = base;
        unique case (s3_reg.op)
            HOP_INC:
            begin
                wr_en   = s3_reg.valid;
                wr_data = base + {{(COUNT_W-1){1'b0}}, 1'b1};
            end
            HOP_CLEAR:
            begin
                wr_en   = s3_reg.valid;
                wr_data = '0;
            end
            HOP_READ:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign res.valid = s3_reg.valid && (s3_reg.op != HOP_INC);
    assign res.count = base;
    assign res.bin   = s3_reg.bin;

endmodule

/* sv/abs_second_derivative_histogram.sv */
`timescale 1ns / 1ps
// Top level of the second derivative sharpness histogram.
// Depends on asdh_pkg, asdh_req_if, asdh_res_if, asdh_deriv and asdh_hist.
//
// Usage:
//   req carries one word per handshake: a grey pixel in raster order
//   (req_type 0), a bin read (1) or a bin read that clears the bin (2).
//   Code 3 is accepted and ignored. res returns one word per read: the
//   count held before any clearing and the bin index.
//   Registers are written through cfg_we / cfg_index / cfg_data while the
//   block is idle; any write restarts the frame at column and row zero.
// Throughput: one word per cycle while req.ready is high. Each pixel
//   costs one line store access (two reads, one write) and one
//   histogram read-modify-write, overlapped in a four-stage pipe with
//   forwarding on back-to-back hits of one bin.
// Path: a read passes s1_reg, op_reg, s3_reg and the queue to res.
// Stalls: results wait in an eight-word queue; req.ready drops while eight
//   reads are outstanding, so a stalled receiver holds off only the input.
// Reset: counters read as zero at once (one filled bit per bin); there is
//   no clearing pass. Line store contents are undefined until written.
module abs_second_derivative_histogram import asdh_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    asdh_req_if.sink              req,
    asdh_res_if.source            res
);

    logic [FW_W-1:0]     width_reg;
    logic [FH_W-1:0]     height_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [INDENT_W-1:0] indent_reg;

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [SLOT_W-1:0] slot_next;

    logic accept;
    logic pix_acc;
    logic rd_acc;
    logic pop;

    logic              step_ok;
    logic [STEP_W-1:0] s_eff;
    logic              settings_ok;
    logic              eligible;

    logic [CALC_W-1:0] w_ext;
    logic [CALC_W-1:0] h_ext;
    logic [CALC_W-1:0] s_ext;
    logic [CALC_W-1:0] se_ext;
    logic [CALC_W-1:0] ind_ext;
    logic [CALC_W-1:0] c_ext;
    logic [CALC_W-1:0] r_ext;
    logic [CALC_W-1:0] c_inc;
    logic [CALC_W-1:0] r_inc;
    logic [CALC_W-1:0] lo_lim;
    logic [CALC_W-1:0] col_hi;
    logic [CALC_W-1:0] row_hi;

    logic [STEP_W:0]   span;
    logic [STEP_W:0]   slot_inc;
    logic [STEP_W:0]   slot_ext;
    logic [STEP_W:0]   slot_mid_ext;
    logic [SLOT_W-1:0] slot_mid;

    ls_req_t   ls_req;
    hist_op_t  hop;
    hist_res_t hres;

    logic [COUNT_W-1:0]  fifo_count_mem [FIFO_DEPTH];
    logic [BIN_W-1:0]    fifo_bin_mem   [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [CREDIT_W-1:0]   fill_reg;
    logic [CREDIT_W-1:0]   credit_reg;

    // Handshakes
    assign req.ready = (credit_reg < CREDIT_W'(FIFO_DEPTH));
    assign accept    = req.valid && req.ready;
    assign pix_acc   = accept && (req.req_type == REQ_PIXEL);
    assign rd_acc    = accept && ((req.req_type == REQ_READ) || (req.req_type == REQ_CLEAR));
    assign pop       = res.valid && res.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FW_W'(MAX_WIDTH);
            height_reg <= FH_W'(MAX_HEIGHT);
            step_reg   <= STEP_W'(1);
            indent_reg <= INDENT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:   width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT:  height_reg <= cfg_data[FH_W-1:0];
                REG_DERIV_STEP:    step_reg   <= cfg_data[STEP_W-1:0];
                REG_BORDER_INDENT: indent_reg <= cfg_data[INDENT_W-1:0];
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // Check the settings and derive the counting window
    assign w_ext   = CALC_W'(width_reg);
    assign h_ext   = CALC_W'(height_reg);
    assign s_ext   = CALC_W'(step_reg);
    assign ind_ext = CALC_W'(indent_reg);
    assign c_ext   = CALC_W'(col_reg);
    assign r_ext   = CALC_W'(row_reg);

    assign step_ok = (step_reg != '0) && (s_ext <= CALC_W'(MAX_STEP));
    assign s_eff   = step_ok ? step_reg : STEP_W'(1);
    assign se_ext  = CALC_W'(s_eff);

    assign settings_ok = step_ok && (ind_ext >= s_ext)
                         && (w_ext <= CALC_W'(MAX_WIDTH)) && (h_ext <= CALC_W'(MAX_HEIGHT))
                         && (w_ext > (ind_ext << 1)) && (h_ext > (ind_ext << 1));

    assign lo_lim = ind_ext + se_ext;
    assign col_hi = w_ext - ind_ext + se_ext;
    assign row_hi = h_ext - ind_ext + se_ext;

    assign eligible = settings_ok && (c_ext >= lo_lim) && (c_ext < col_hi)
                      && (r_ext >= lo_lim) && (r_ext < row_hi);

    // Slot of this row and of the centre row, step rows up
    assign span         = {s_eff, 1'b0};
    assign slot_ext     = (STEP_W+1)'(slot_reg);
    assign slot_inc     = slot_ext + {{STEP_W{1'b0}}, 1'b1};
    assign slot_mid_ext = (slot_ext >= {1'b0, s_eff}) ? slot_ext - {1'b0, s_eff}
                                                      : slot_ext + {1'b0, s_eff};
    assign slot_mid     = slot_mid_ext[SLOT_W-1:0];

    // Advance column, row and slot
    assign c_inc = c_ext + CALC_W'(1);
    assign r_inc = r_ext + CALC_W'(1);

    always_comb
    begin
        col_next  = c_inc[COL_W-1:0];
        row_next  = row_reg;
        slot_next = slot_reg;
        if ((c_inc >= w_ext) || (c_inc >= CALC_W'(MAX_WIDTH)))
        begin
            col_next = '0;
            if ((r_inc >= h_ext) || (r_inc >= CALC_W'(MAX_HEIGHT)))
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = r_inc[ROW_W-1:0];
                slot_next = (slot_inc >= span) ? '0 : slot_inc[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // Word for the line store stage
    always_comb
    begin
        ls_req.valid    = pix_acc || rd_acc;
        ls_req.is_pixel = pix_acc;
        ls_req.count_en = eligible;
        ls_req.op       = (req.req_type == REQ_CLEAR) ? HOP_CLEAR : HOP_READ;
        ls_req.pix      = req.pixel_value;
        ls_req.bin      = req.bin_select;
        ls_req.addr_now = LS_ADDR_W'(slot_reg) * LS_ADDR_W'(MAX_WIDTH) + LS_ADDR_W'(col_reg);
        ls_req.addr_mid = LS_ADDR_W'(slot_mid) * LS_ADDR_W'(MAX_WIDTH) + LS_ADDR_W'(col_reg);
    end

    asdh_deriv u_deriv (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s_eff),
        .req   (ls_req),
        .op    (hop)
    );

    asdh_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (hop),
        .res   (hres)
    );

    // Queue results; one credit per read in flight or waiting
    always_ff @(posedge clk)
    begin
        if (hres.valid)
        begin
            fifo_count_mem[wr_ptr_reg] <= hres.count;
            fifo_bin_mem[wr_ptr_reg]   <= hres.bin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (hres.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            priority if (hres.valid && !pop)
            begin
                fill_reg <= fill_reg + CREDIT_W'(1);
            end
            else if (!hres.valid && pop)
            begin
                fill_reg <= fill_reg - CREDIT_W'(1);
            end
            else
            begin
                fill_reg <= fill_reg;
            end
            priority if (rd_acc && !pop)
            begin
                credit_reg <= credit_reg + CREDIT_W'(1);
            end
            else if (!rd_acc && pop)
            begin
                credit_reg <= credit_reg - CREDIT_W'(1);
            end
            else
            begin
                credit_reg <= credit_reg;
            end
        end
    end

    assign res.valid     = (fill_reg != '0);
    assign res.bin_count = fifo_count_mem[rd_ptr_reg];
    assign res.bin_echo  = fifo_bin_mem[rd_ptr_reg];

endmodule
